>>> rtl/log_structured_block_remap_macros.svh
// Assertion macros for the log-structured block remapper.
`ifndef LOG_STRUCTURED_BLOCK_REMAP_MACROS_SVH
`define LOG_STRUCTURED_BLOCK_REMAP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSBR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lsbr_pkg.sv
// Package for the log-structured block remapper: constants, codes and state type.
`default_nettype none

package lsbr_pkg;

  localparam int unsigned MAP_BLOCKS    = 65536;
  localparam int unsigned SECTOR_W      = 32;
  localparam int unsigned LEN_W         = 12;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned ACT_W         = 2;
  localparam int unsigned CFG_W         = 17;
  localparam int unsigned BLK_W         = SECTOR_W - 3;
  localparam int unsigned CNT_W         = LEN_W - 3;
  localparam int unsigned S_DATA_W      = 48;
  localparam int unsigned ENTRY_W       = SECTOR_W + 1;
  localparam logic [CFG_W-1:0] BLOCKS_RESET = 17'd65536;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;

  localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ZERO    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WRITTEN = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

>>> rtl/lsbr_ram.sv
// Generic simple dual-port RAM with registered read and read enable.
`default_nettype none

module lsbr_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/log_structured_block_remap.sv
// Log-structured block remapper: one map entry per 4 KiB block of 8 sectors. Writes
// are placed at a running write pointer and the map records where each block went;
// reads of mapped blocks are redirected, reads of never-written blocks complete
// zero-filled, everything else passes through. One result per transfer in. After
// reset a clearing pass sweeps the map memory, one entry per cycle, through all MapBlocks
// entries while s_tready stays low (configuration writes are taken meanwhile).
// Per item: pass-through items are answered directly, a read of a block below the
// limit first does one map memory read, and a write steps through max(len/8,1) blocks
// through the single map write port that stores one entry per cycle. The output
// register lets the next item be taken in the cycle its predecessor's result leaves.
`default_nettype none

module log_structured_block_remap #(
  parameter int unsigned MapBlocks = lsbr_pkg::MAP_BLOCKS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lsbr_pkg::CFG_W-1:0]    cfg_wr_data,  // blocks_in_use
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lsbr_pkg::S_DATA_W-1:0] s_tdata,      // [31:0] start_sector, [43:32] length_sectors
  input  wire logic [lsbr_pkg::CMD_W-1:0]    s_tuser,      // [1:0] command
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lsbr_pkg::SECTOR_W-1:0]      m_tdata,      // [31:0] target_sector
  output logic [lsbr_pkg::ACT_W-1:0]         m_tuser       // [1:0] action
);

  `include "log_structured_block_remap_macros.svh"

  localparam int unsigned AddrW = $clog2(MapBlocks);
  localparam int unsigned BLK_W = lsbr_pkg::BLK_W;
  localparam int unsigned CNT_W = lsbr_pkg::CNT_W;
  localparam int unsigned SW    = lsbr_pkg::SECTOR_W;

  lsbr_pkg::state_t state, state_next;

  logic [lsbr_pkg::CFG_W-1:0] blocks_in_use;
  logic [SW-1:0]              write_pointer;
  logic [SW-1:0]              sector_q;
  logic [lsbr_pkg::LEN_W-1:0] len_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [CNT_W-1:0]           idx;
  logic [AddrW-1:0]           clr_idx;

  logic                       out_valid;
  logic [lsbr_pkg::ACT_W-1:0] out_action;
  logic [SW-1:0]              out_target;

  logic                               ram_we;
  logic [AddrW-1:0]                   ram_waddr;
  logic [lsbr_pkg::ENTRY_W-1:0]       ram_wdata;
  logic                               ram_re;
  logic [lsbr_pkg::ENTRY_W-1:0]       ram_rdata;

  logic [SW-1:0]              in_sector;
  logic [lsbr_pkg::LEN_W-1:0] in_len;
  logic [lsbr_pkg::CMD_W-1:0] in_cmd;
  logic [BLK_W-1:0]           in_blk;
  logic                       accept;
  logic                       in_read_hit;
  logic [BLK_W:0]             wr_blk;
  logic                       wr_in_limit;
  logic                       wr_last;
  logic                       clr_last;
  logic                       load_out;
  logic [lsbr_pkg::ACT_W-1:0] load_action;
  logic [SW-1:0]              load_target;

  function automatic logic below_limit(input logic [SW-1:0] b,
                                       input logic [lsbr_pkg::CFG_W-1:0] biu);
    logic lt_cfg;
    logic lt_map;
    lt_cfg = b < {{(SW-lsbr_pkg::CFG_W){1'b0}}, biu};
    lt_map = b < SW'(MapBlocks);
    return lt_cfg && lt_map;
  endfunction

  assign in_sector = s_tdata[SW-1:0];
  assign in_len    = s_tdata[SW+lsbr_pkg::LEN_W-1:SW];
  assign in_cmd    = s_tuser;
  assign in_blk    = in_sector[SW-1:3];
  assign accept    = s_tvalid && s_tready;

  assign in_read_hit = (in_cmd == lsbr_pkg::CMD_READ) && (in_len != '0) &&
                       below_limit({3'b000, in_blk}, blocks_in_use);

  assign wr_blk      = {1'b0, sector_q[SW-1:3]} + {{(BLK_W+1-CNT_W){1'b0}}, idx};
  assign wr_in_limit = below_limit({2'b00, wr_blk}, blocks_in_use);
  assign wr_last     = (idx == cnt_q - CNT_W'(1));
  assign clr_last    = (clr_idx == AddrW'(MapBlocks - 1));

  assign s_tready = (state == lsbr_pkg::ST_IDLE) && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_target;
  assign m_tuser  = out_action;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsbr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_waddr   = clr_idx;
    ram_wdata   = {1'b0, {SW{1'b1}}};
    ram_re      = 1'b0;
    load_out    = 1'b0;
    load_action = lsbr_pkg::ACT_FORWARD;
    load_target = in_sector;
    case (state)
      lsbr_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_last) begin
          state_next = lsbr_pkg::ST_IDLE;
        end
      end
      lsbr_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == lsbr_pkg::CMD_WRITE && in_len != '0) begin
            state_next = lsbr_pkg::ST_WRITE;
          end else if (in_read_hit) begin
            ram_re     = 1'b1;
            state_next = lsbr_pkg::ST_READ;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      lsbr_pkg::ST_WRITE: begin
        ram_we    = wr_in_limit;
        ram_waddr = wr_blk[AddrW-1:0];
        ram_wdata = {1'b1, write_pointer + {{(SW-CNT_W-3){1'b0}}, idx, 3'b000}};
        if (wr_last) begin
          load_out    = 1'b1;
          load_action = lsbr_pkg::ACT_WRITTEN;
          load_target = '0;
          state_next  = lsbr_pkg::ST_IDLE;
        end
      end
      lsbr_pkg::ST_READ: begin
        load_out = 1'b1;
        if (ram_rdata[SW]) begin
          load_action = lsbr_pkg::ACT_FORWARD;
          load_target = ram_rdata[SW-1:0] + {{(SW-3){1'b0}}, sector_q[2:0]};
        end else begin
          load_action = lsbr_pkg::ACT_ZERO;
          load_target = '0;
        end
        state_next = lsbr_pkg::ST_IDLE;
      end
      default: begin
        state_next = lsbr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= lsbr_pkg::BLOCKS_RESET;
      write_pointer <= '0;
      clr_idx       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blocks_in_use <= cfg_wr_data;
      end
      if (state == lsbr_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + AddrW'(1);
      end
      if (state == lsbr_pkg::ST_WRITE && wr_last) begin
        write_pointer <= write_pointer + {{(SW-lsbr_pkg::LEN_W){1'b0}}, len_q};
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sector_q <= in_sector;
      len_q    <= in_len;
      cnt_q    <= (in_len[lsbr_pkg::LEN_W-1:3] == '0) ? CNT_W'(1)
                                                      : in_len[lsbr_pkg::LEN_W-1:3];
      idx      <= '0;
    end else if (state == lsbr_pkg::ST_WRITE) begin
      idx <= idx + CNT_W'(1);
    end
    if (load_out) begin
      out_action <= load_action;
      out_target <= load_target;
    end
  end

  lsbr_ram #(
    .WIDTH (lsbr_pkg::ENTRY_W),
    .DEPTH (MapBlocks)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_blk[AddrW-1:0]),
    .rdata (ram_rdata)
  );

  `LSBR_ASSERT_NOW(a_no_accept_in_clear, clk, rst, state == lsbr_pkg::ST_CLEAR, !s_tready, "transfer accepted during map clear")
  `LSBR_ASSERT_NOW(a_out_free_on_load, clk, rst, load_out, !out_valid || m_tready, "result overwrites a pending result")
  `LSBR_ASSERT_NEXT(a_wp_only_on_write, clk, rst, state != lsbr_pkg::ST_WRITE, $stable(write_pointer), "write pointer moved outside a write")

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Testbench for the log-structured block remapper: predictor, stimulus tasks and result checks.
module testbench;

  localparam logic [lsbr_pkg::CMD_W-1:0] CMD_OTHER = 2'd2;
  localparam logic [lsbr_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 300000;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct packed {
    logic [lsbr_pkg::ACT_W-1:0]    action;
    logic [lsbr_pkg::SECTOR_W-1:0] target;
  } remap_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [lsbr_pkg::CFG_W-1:0]    cfg_wr_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [lsbr_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic [lsbr_pkg::CMD_W-1:0]    s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [lsbr_pkg::SECTOR_W-1:0] m_tdata;
  logic [lsbr_pkg::ACT_W-1:0]    m_tuser;

  log_structured_block_remap dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always #6 clk = ~clk;

  // Mirror of the block's state
  logic [lsbr_pkg::SECTOR_W-1:0] sector_of_block [int unsigned];
  logic [lsbr_pkg::SECTOR_W-1:0] next_free_sector = '0;
  int unsigned                   blocks_in_use = 65536;
  remap_result_t                 pending_results [$];

  int unsigned fail_count = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_request = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned win_base = 0;

  function automatic int unsigned mapped_limit();
    return (blocks_in_use > lsbr_pkg::MAP_BLOCKS) ? lsbr_pkg::MAP_BLOCKS : blocks_in_use;
  endfunction

  function automatic remap_result_t remap_predict(logic [lsbr_pkg::CMD_W-1:0] cmd,
                                                  logic [lsbr_pkg::SECTOR_W-1:0] sector,
                                                  logic [lsbr_pkg::LEN_W-1:0] len);
    remap_result_t res;
    int unsigned   blk, lim, count;
    blk = sector >> 3;
    lim = mapped_limit();
    res.action = lsbr_pkg::ACT_FORWARD;
    res.target = sector;
    if (len == 0) return res;
    if (cmd == lsbr_pkg::CMD_WRITE) begin
      count = 32'(len >> 3);
      if (count == 0) count = 1;
      for (int unsigned i = 0; i < count; i++)
        if (blk + i < lim) sector_of_block[blk + i] = next_free_sector + (i << 3);
      next_free_sector += lsbr_pkg::SECTOR_W'(len);
      res.action = lsbr_pkg::ACT_WRITTEN;
      res.target = '0;
    end else if (cmd == lsbr_pkg::CMD_READ && blk < lim) begin
      if (sector_of_block.exists(blk)) begin
        res.target = sector_of_block[blk] + lsbr_pkg::SECTOR_W'(sector[2:0]);
      end else begin
        res.action = lsbr_pkg::ACT_ZERO;
        res.target = '0;
      end
    end
    return res;
  endfunction

  task automatic send_item(input logic [lsbr_pkg::CMD_W-1:0] cmd,
                           input logic [lsbr_pkg::SECTOR_W-1:0] sector,
                           input logic [lsbr_pkg::LEN_W-1:0] len);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(lsbr_pkg::S_DATA_W - lsbr_pkg::LEN_W - lsbr_pkg::SECTOR_W){1'b0}},
                 len, sector};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(remap_predict(cmd, sector, len));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_blocks_in_use(input int unsigned value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lsbr_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    blocks_in_use = value;
  endtask

  function automatic int unsigned pick_block();
    int unsigned lim, r;
    lim = mapped_limit();
    r = $urandom_range(0, 99);
    if (r < 70) return win_base + $urandom_range(0, 31);
    if (r < 88) return ((lim > 4) ? lim - 4 : 0) + $urandom_range(0, 8);
    return $urandom_range(0, 32'h1FFF_FFFF);
  endfunction

  function automatic logic [lsbr_pkg::LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 60) return lsbr_pkg::LEN_W'($urandom_range(1, 16));
    if (r < 93) return lsbr_pkg::LEN_W'($urandom_range(17, 128));
    return lsbr_pkg::LEN_W'($urandom_range(129, 4095));
  endfunction

  task automatic random_items(input int unsigned n);
    logic [lsbr_pkg::CMD_W-1:0]    cmd;
    logic [lsbr_pkg::SECTOR_W-1:0] sector;
    logic [lsbr_pkg::LEN_W-1:0]    len;
    int unsigned                   pick;
    repeat (n) begin
      pick   = $urandom_range(0, 99);
      sector = (pick_block() << 3) | $urandom_range(0, 7);
      len    = pick_len();
      if (pick < 42) begin
        cmd = lsbr_pkg::CMD_WRITE;
      end else if (pick < 86) begin
        cmd = lsbr_pkg::CMD_READ;
      end else if (pick < 93) begin
        cmd = CMD_OTHER;
      end else begin
        // noise: random sector and length, command 0 to 2
        cmd    = lsbr_pkg::CMD_W'($urandom_range(0, 2));
        sector = $urandom;
        len    = lsbr_pkg::LEN_W'($urandom);
      end
      send_item(cmd, sector, len);
    end
  endtask

  task automatic test_directed();
    set_blocks_in_use(65536);
    send_item(lsbr_pkg::CMD_READ, 32'h0000_0000, 12'd8);         // never written
    send_item(CMD_OTHER, 32'hFFFF_FFFF, 12'hFFF);
    send_item(CMD_SPARE, 32'h1234_5678, 12'd1);
    send_item(lsbr_pkg::CMD_WRITE, 32'h0000_0080, 12'd0);        // zero length
    send_item(lsbr_pkg::CMD_READ, 32'h0000_0085, 12'd0);
    send_item(lsbr_pkg::CMD_WRITE, 32'h0000_0010, 12'd1);
    send_item(lsbr_pkg::CMD_READ, 32'h0000_0017, 12'd1);
    send_item(lsbr_pkg::CMD_WRITE, 32'h0000_0100, 12'hFFF);      // 511 blocks
    send_item(lsbr_pkg::CMD_READ, 32'h0000_10F3, 12'd4);
    send_item(lsbr_pkg::CMD_READ, 32'h0000_0103, 12'd4);
    send_item(lsbr_pkg::CMD_READ, 32'h0007_FFFD, 12'd1);         // last block, unmapped
    send_item(lsbr_pkg::CMD_WRITE, 32'h0007_FFF8, 12'd16);       // straddles the limit
    send_item(lsbr_pkg::CMD_READ, 32'h0007_FFFD, 12'd2);
    send_item(lsbr_pkg::CMD_READ, 32'h0008_0000, 12'd2);         // past the limit
    send_item(lsbr_pkg::CMD_READ, 32'hFFFF_FFFF, 12'hFFF);
    send_item(lsbr_pkg::CMD_WRITE, 32'hFFFF_FFF8, 12'hFFF);      // all blocks past the limit
    send_item(lsbr_pkg::CMD_WRITE, 32'h0000_0200, 12'd7);
    send_item(lsbr_pkg::CMD_WRITE, 32'h0000_0208, 12'd8);
    send_item(lsbr_pkg::CMD_WRITE, 32'h0000_0210, 12'd15);
    send_item(lsbr_pkg::CMD_READ, 32'h0000_0201, 12'd1);
    send_item(lsbr_pkg::CMD_READ, 32'h0000_020E, 12'd1);
    send_item(lsbr_pkg::CMD_READ, 32'h0000_0217, 12'd1);
  endtask

  task automatic test_limit_one();
    set_blocks_in_use(1);
    send_item(lsbr_pkg::CMD_WRITE, 32'h0000_0000, 12'd16);
    send_item(lsbr_pkg::CMD_READ, 32'h0000_0003, 12'd1);
    send_item(lsbr_pkg::CMD_READ, 32'h0000_0008, 12'd1);
    send_item(lsbr_pkg::CMD_READ, 32'h0000_0012, 12'd1);   // mapped earlier, now past the limit
    send_item(lsbr_pkg::CMD_WRITE, 32'h0000_0018, 12'd8);
    win_base = 0;
    random_items(100);
  endtask

  task automatic test_limit_sweep();
    int unsigned sweep [5];
    sweep = '{97, 4096, 0, 65535, 65536};
    sweep[2] = $urandom_range(2, 65534);
    for (int k = 0; k < 5; k++) begin
      set_blocks_in_use(sweep[k]);
      win_base = $urandom_range(0, mapped_limit() - 1);
      idle_on  = (k != 3);
      random_items(190);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_blocks_in_use(2048);
    win_base     = $urandom_range(0, 2047);
    idle_on      = 1'b0;
    hold_request = LONG_HOLD;
    random_items(60);
  endtask

  task automatic test_no_idle();
    set_blocks_in_use(65536);
    win_base = $urandom_range(0, 65535);
    idle_on  = 1'b0;
    random_items(250);
  endtask

  // Receiver ready: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (hold_request != 0) begin
      m_tready <= 1'b0;
      stall_left   = hold_request;
      hold_request = 0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    remap_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer: action %0d target %08h", $time, m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.action) begin
          $display("%0t: action mismatch: expected %0d, actual %0d",
                   $time, want.action, m_tuser);
          fail_count++;
        end
        if (m_tdata !== want.target) begin
          $display("%0t: target_sector mismatch: expected %08h, actual %08h",
                   $time, want.target, m_tdata);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_limit_one();
    test_limit_sweep();
    test_backpressure();
    test_no_idle();
    wait_idle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
